FILE: rtl/pci_pkg.sv
// ----------------------------------------------------------------------------
// pci_pkg
// Shared types, register codes, constants and the Q2.30 multiply helper for
// the parameter curve interpolator.
// ----------------------------------------------------------------------------
package pci_pkg;

	localparam int TIME_WIDTH_DEF    = 32;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int DATA_W            = 32;
	localparam int SHAPE_W           = 3;
	localparam int CFG_IDX_W         = 3;
	localparam int ACC_W             = 36;
	localparam int SINE_STEPS        = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_TIME  = 3'd0,
		REG_END_TIME    = 3'd1,
		REG_START_VALUE = 3'd2,
		REG_END_VALUE   = 3'd3,
		REG_CURVE_SHAPE = 3'd4
	} cfg_reg_t;

	typedef enum logic [SHAPE_W-1:0] {
		SHAPE_JUMP   = 3'd0,
		SHAPE_LINEAR = 3'd1,
		SHAPE_SQUARE = 3'd2,
		SHAPE_SQRT   = 3'd3,
		SHAPE_SINE   = 3'd4
	} shape_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] start_time;
		logic signed [DATA_W-1:0] end_time;
		logic signed [DATA_W-1:0] start_value;
		logic signed [DATA_W-1:0] end_value;
		logic [SHAPE_W-1:0]       curve_shape;
	} cfg_t;

	localparam logic signed [ACC_W-1:0] Q30_ONE  = 36'sd1073741824;
	localparam logic signed [ACC_W-1:0] Q30_HALF = 36'sd536870912;

	// odd polynomial for sin(pi*t), t in [-1/2, 1/2], coefficients of t^1 .. t^13
	localparam logic signed [ACC_W-1:0] SINE_COEF [0:6] = '{
		36'sd3373259426, -36'sd5548789346, 36'sd2738217788, -36'sd643455389,
		36'sd88203474, -36'sd7913940, 36'sd500689
	};

	// (a * b) / 2^30 truncated toward zero, |a| < 2^34, |b| <= 2^30
	function automatic logic signed [ACC_W-1:0] mul_q30(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic [ACC_W-1:0] ma;
		logic [ACC_W-1:0] mb;
		logic [65:0]      p;
		logic [ACC_W-1:0] q;
		ma = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
		mb = b[ACC_W-1] ? ACC_W'(-b) : ACC_W'(b);
		p  = 66'(ma[34:0]) * 66'(mb[30:0]);
		q  = p[65:30];
		return (a[ACC_W-1] ^ b[ACC_W-1]) ? -signed'(q) : signed'(q);
	endfunction

endpackage

FILE: rtl/pci_if.sv
// ----------------------------------------------------------------------------
// pci_if
// Valid/ready channels of the parameter curve interpolator.
// ----------------------------------------------------------------------------
interface pci_in_if import pci_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] time_offset;

	modport source (output valid, output time_offset, input ready);
	modport sink (input valid, input time_offset, output ready);
endinterface

interface pci_out_if import pci_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] curve_value;

	modport source (output valid, output curve_value, input ready);
	modport sink (input valid, input curve_value, output ready);
endinterface

FILE: rtl/pci_div.sv
// ----------------------------------------------------------------------------
// pci_div
// Clamps the time offset to the span and divides it by the span, one
// quotient bit per pipeline stage, giving x in unsigned Q1.F, 0 .. 1.
// ----------------------------------------------------------------------------
module pci_div import pci_pkg::*; #(
	parameter int TIME_WIDTH    = TIME_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	input  logic signed [DATA_W-1:0] time_offset,
	output logic                     out_valid,
	output logic [FRACTION_BITS:0]   x
);

	localparam int TW  = TIME_WIDTH;
	localparam int F   = FRACTION_BITS;
	localparam int NST = F + 1;

	logic signed [TW-1:0] t0;
	logic signed [TW-1:0] t1;
	logic signed [TW-1:0] off;
	logic signed [TW:0]   span_w;
	logic [TW-1:0]        span;
	logic [TW-1:0]        off_c;
	logic                 q_top;
	logic [TW-1:0]        rem0;

	logic [NST-1:0] v_s;
	logic [TW-1:0]  rem_s [NST];
	logic [F:0]     q_s   [NST];

	assign t0     = cfg.start_time[TW-1:0];
	assign t1     = cfg.end_time[TW-1:0];
	assign off    = time_offset[TW-1:0];
	assign span_w = (TW+1)'(t1) - (TW+1)'(t0);
	assign span   = span_w[TW-1:0];

	// negative offset counts as zero, beyond the span as the span
	always_comb begin
		if (off[TW-1]) begin
			off_c = '0;
		end else if ((TW+1)'(off) > span_w) begin
			off_c = span;
		end else begin
			off_c = off;
		end
	end

	assign q_top = (off_c == span);
	assign rem0  = q_top ? '0 : off_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rem0;
			q_s[0]   <= (F+1)'(q_top);
		end
	end

	for (genvar k = 1; k < NST; k++) begin : g_step
		logic [TW:0] rem2;
		logic [TW:0] diff;
		logic        ge;

		assign rem2 = {rem_s[k-1], 1'b0};
		assign diff = rem2 - {1'b0, span};
		assign ge   = (rem2 >= {1'b0, span});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[TW-1:0] : rem2[TW-1:0];
				q_s[k]   <= {q_s[k-1][F-1:0], ge};
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign x         = q_s[NST-1];

endmodule

FILE: rtl/pci_shape.sv
// ----------------------------------------------------------------------------
// pci_shape
// Shapes x into the square, square root and half-cosine curves side by side.
// The root takes one bit per stage, the sine one Horner step per stage.
// ----------------------------------------------------------------------------
module pci_shape import pci_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [FRACTION_BITS:0] x_in,
	output logic                   out_valid,
	output logic [FRACTION_BITS:0] x_out,
	output logic [FRACTION_BITS:0] y_sq,
	output logic [FRACTION_BITS:0] y_rt,
	output logic [FRACTION_BITS:0] y_sn
);

	localparam int F  = FRACTION_BITS;
	localparam int NS = (F + 1 > SINE_STEPS) ? F + 1 : SINE_STEPS;
	localparam int RW = F + 4;
	localparam int VW = 2 * F + 2;

	logic [NS-1:0]           v_s;
	logic [F:0]              x_s   [NS];
	logic [F:0]              sq_s  [NS];
	logic [F:0]              rt_s  [NS];
	logic [RW-1:0]           rr_s  [NS];
	logic [F:0]              sn_s  [NS];
	logic signed [ACC_W-1:0] t_s   [NS];
	logic signed [ACC_W-1:0] t2_s  [NS];
	logic signed [ACC_W-1:0] acc_s [NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NS-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int PI = (k <= F) ? F - k : 0;
		localparam int CI = (k >= 2 && k <= 7) ? 7 - k : 0;

		logic [F:0]              px, psq, prt, psn;
		logic [RW-1:0]           prr;
		logic signed [ACC_W-1:0] pt, pt2, pacc;
		logic [F:0]              nsq, nrt, nsn;
		logic [RW-1:0]           nrr;
		logic signed [ACC_W-1:0] nt, nt2, nacc;

		if (k == 0) begin : g_first
			assign px   = x_in;
			assign psq  = '0;
			assign prt  = '0;
			assign psn  = '0;
			assign prr  = '0;
			assign pt   = '0;
			assign pt2  = '0;
			assign pacc = '0;
		end else begin : g_next
			assign px   = x_s[k-1];
			assign psq  = sq_s[k-1];
			assign prt  = rt_s[k-1];
			assign psn  = sn_s[k-1];
			assign prr  = rr_s[k-1];
			assign pt   = t_s[k-1];
			assign pt2  = t2_s[k-1];
			assign pacc = acc_s[k-1];
		end

		always_comb begin
			logic [VW-1:0]         sqp;
			logic [VW-1:0]         vv;
			logic [RW-1:0]         r2;
			logic [RW-1:0]         trial;
			logic signed [ACC_W:0] sv;
			logic [ACC_W:0]        su;
			logic [ACC_W:0]        lim;
			nsq   = psq;
			nrt   = prt;
			nrr   = prr;
			nsn   = psn;
			nt    = pt;
			nt2   = pt2;
			nacc  = pacc;
			sqp   = VW'(px) * VW'(px) + (VW'(1) << (F - 1));
			vv    = VW'(px) << F;
			r2    = {prr[RW-3:0], vv[2*PI +: 2]};
			trial = RW'({prt, 2'b01});
			sv    = (ACC_W+1)'(pacc) + (ACC_W+1)'(Q30_ONE);
			lim   = (ACC_W+1)'(1) << F;
			if (sv[ACC_W]) begin
				sv = '0;
			end
			su = (unsigned'(sv) + ((ACC_W+1)'(1) << (30 - F))) >> (31 - F);

			if (k == 0) begin
				nsq = sqp[2*F:F];
			end
			// square root, two radicand bits per stage
			if (k <= F) begin
				if (r2 >= trial) begin
					nrr = r2 - trial;
					nrt = {prt[F-1:0], 1'b1};
				end else begin
					nrr = r2;
					nrt = {prt[F-1:0], 1'b0};
				end
			end
			// half-cosine: t = x - 1/2 in Q2.30, odd polynomial by Horner
			if (k == 0) begin
				nt = signed'(ACC_W'(px) << (30 - F)) - Q30_HALF;
			end
			if (k == 1) begin
				nt2  = mul_q30(pt, pt);
				nacc = SINE_COEF[6];
			end
			if (k >= 2 && k <= 7) begin
				nacc = SINE_COEF[CI] + mul_q30(pacc, pt2);
			end
			if (k == 8) begin
				nacc = mul_q30(pacc, pt);
			end
			if (k == 9) begin
				nsn = (su > lim) ? lim[F:0] : su[F:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]   <= px;
				sq_s[k]  <= nsq;
				rt_s[k]  <= nrt;
				rr_s[k]  <= nrr;
				sn_s[k]  <= nsn;
				t_s[k]   <= nt;
				t2_s[k]  <= nt2;
				acc_s[k] <= nacc;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign x_out     = x_s[NS-1];
	assign y_sq      = sq_s[NS-1];
	assign y_rt      = rt_s[NS-1];
	assign y_sn      = sn_s[NS-1];

endmodule

FILE: rtl/pci_blend.sv
// ----------------------------------------------------------------------------
// pci_blend
// Picks the shaped fraction, blends start and end values with it, rounds and
// saturates, and holds the result in an output register with a skid slot.
// ----------------------------------------------------------------------------
module pci_blend import pci_pkg::*; #(
	parameter int TIME_WIDTH    = TIME_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	output logic                     en,
	input  logic                     in_valid,
	input  logic [FRACTION_BITS:0]   x,
	input  logic [FRACTION_BITS:0]   y_sq,
	input  logic [FRACTION_BITS:0]   y_rt,
	input  logic [FRACTION_BITS:0]   y_sn,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] curve_value
);

	localparam int TW = TIME_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int DW = DATA_W + 1;
	localparam int PW = DATA_W + F + 3;

	logic signed [TW-1:0] t0;
	logic signed [TW-1:0] t1;
	logic signed [TW:0]   span_w;
	logic [F:0]           y_sel;
	logic                 byp;

	logic                 v_s1, v_s2, v_s3;
	logic [F:0]           y_s1;
	logic signed [DW-1:0] diff_s1;
	logic                 byp_s1, byp_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [DATA_W-1:0] res_s3;
	logic signed [PW-1:0] sum;
	logic signed [PW-1:0] r;
	logic signed [DATA_W-1:0] res;
	logic                 skid_full_q;
	logic signed [DATA_W-1:0] skid_q;

	assign t0     = cfg.start_time[TW-1:0];
	assign t1     = cfg.end_time[TW-1:0];
	assign span_w = (TW+1)'(t1) - (TW+1)'(t0);

	always_comb begin
		byp = (span_w <= 0);
		case (cfg.curve_shape)
			SHAPE_LINEAR: y_sel = x;
			SHAPE_SQUARE: y_sel = y_sq;
			SHAPE_SQRT:   y_sel = y_rt;
			SHAPE_SINE:   y_sel = y_sn;
			default: begin
				y_sel = '0;
				byp   = 1'b1;
			end
		endcase
	end

	// pipeline moves while the skid slot is free
	assign en = !skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		sum = prod_s2 + (PW'(1) << (F - 1));
		r   = PW'(cfg.start_value) + (sum >>> F);
		if ((&r[PW-1:DATA_W-1]) || !(|r[PW-1:DATA_W-1])) begin
			res = r[DATA_W-1:0];
		end else if (r[PW-1]) begin
			res = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(DATA_W-1){1'b1}}};
		end
		if (byp_s2) begin
			res = cfg.end_value;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1    <= y_sel;
			diff_s1 <= DW'(cfg.end_value) - DW'(cfg.start_value);
			byp_s1  <= byp;
			prod_s2 <= PW'(diff_s1) * PW'(signed'({1'b0, y_s1}));
			byp_s2  <= byp_s1;
			res_s3  <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (v_s3 && !out_ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && v_s3 && !out_ready) begin
			skid_q <= res_s3;
		end
	end

	assign out_valid   = skid_full_q || v_s3;
	assign curve_value = skid_full_q ? skid_q : res_s3;

endmodule

FILE: rtl/parameter_curve_interpolator_unit.sv
// ----------------------------------------------------------------------------
// parameter_curve_interpolator_unit
// Evaluates one point of a parameter envelope curve per input word.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the skid slot is free and returns one word
// per input, in order. The offset/span divider and the square root each
// produce one result bit per stage, and the sine polynomial uses one Horner
// step per stage. The output register has a one-word skid slot, so input is
// still taken in the cycle in which the consumer first stalls. Configuration
// writes must only happen while no words are in flight.
module parameter_curve_interpolator_unit import pci_pkg::*; #(
	parameter int TIME_WIDTH    = TIME_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pci_in_if.sink               in_ch,
	pci_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	localparam int F = FRACTION_BITS;

	cfg_t       cfg_q;
	logic       en;
	logic       div_valid;
	logic [F:0] div_x;
	logic       shp_valid;
	logic [F:0] shp_x, shp_sq, shp_rt, shp_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_time  <= '0;
			cfg_q.end_time    <= '0;
			cfg_q.start_value <= '0;
			cfg_q.end_value   <= '0;
			cfg_q.curve_shape <= SHAPE_SINE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_TIME:  cfg_q.start_time  <= cfg_data;
				REG_END_TIME:    cfg_q.end_time    <= cfg_data;
				REG_START_VALUE: cfg_q.start_value <= cfg_data;
				REG_END_VALUE:   cfg_q.end_value   <= cfg_data;
				REG_CURVE_SHAPE: cfg_q.curve_shape <= cfg_data[SHAPE_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = en;

	pci_div #(
		.TIME_WIDTH    (TIME_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.cfg         (cfg_q),
		.in_valid    (in_ch.valid),
		.time_offset (in_ch.time_offset),
		.out_valid   (div_valid),
		.x           (div_x)
	);

	pci_shape #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_shape (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.x_in      (div_x),
		.out_valid (shp_valid),
		.x_out     (shp_x),
		.y_sq      (shp_sq),
		.y_rt      (shp_rt),
		.y_sn      (shp_sn)
	);

	pci_blend #(
		.TIME_WIDTH    (TIME_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.en          (en),
		.in_valid    (shp_valid),
		.x           (shp_x),
		.y_sq        (shp_sq),
		.y_rt        (shp_rt),
		.y_sn        (shp_sn),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.curve_value (out_ch.curve_value)
	);

endmodule

FILE: rtl/pci_checker.sv
// ----------------------------------------------------------------------------
// pci_checker
// Port-level checks of the curve interpolator: output hold under stall and
// the link between input backpressure and a waiting result.
// ----------------------------------------------------------------------------
module pci_checker import pci_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] curve_value
);

	// input is only refused while a result waits
	a_backpressure_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input refused with no result pending");

	// one delivery frees the skid slot
	a_ready_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready)
		else $error("input still refused after a result was taken");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(curve_value))
		else $error("result changed while stalled");

	// input valid is observed for completeness of the port view
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$isunknown(in_ready))
		else $error("input ready unknown after a transfer");

endmodule

bind parameter_curve_interpolator_unit pci_checker u_pci_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.curve_value (out_ch.curve_value)
);
